FILE: design/sst_pkg.sv
`default_nettype none
package sst_pkg;

  localparam int MAX_TEXT_LEN = 1048576;
  localparam int WORD_BUFFER_CHARS = 9;
  localparam int POS_W = $clog2(MAX_TEXT_LEN) + 1;
  localparam int START_W = 20;
  localparam int LEN_W = 21;
  localparam int WIDX_W = $clog2(WORD_BUFFER_CHARS);

  // token kinds that the scanner names directly
  localparam logic [6:0] K_WS = 7'd0;
  localparam logic [6:0] K_LT = 7'd1;
  localparam logic [6:0] K_ID = 7'd2;
  localparam logic [6:0] K_NUM = 7'd3;
  localparam logic [6:0] K_STR = 7'd4;
  localparam logic [6:0] K_INC = 7'd20;
  localparam logic [6:0] K_DEC = 7'd21;
  localparam logic [6:0] K_AND = 7'd18;
  localparam logic [6:0] K_OR = 7'd19;
  localparam logic [6:0] K_NONE = 7'd0;
  localparam logic [6:0] K_END = 7'd51;
  localparam logic [6:0] K_WORD0 = 7'd52;

  // error codes
  localparam logic [2:0] E_OK = 3'd0;
  localparam logic [2:0] E_UNTERM = 3'd1;
  localparam logic [2:0] E_NL_STR = 3'd2;
  localparam logic [2:0] E_ESCAPE = 3'd3;
  localparam logic [2:0] E_BAD_CHAR = 3'd4;
  localparam logic [2:0] E_BAD_NUM = 3'd5;
  localparam logic [2:0] E_TOO_LONG = 3'd6;

  // punctuator prefix codes
  localparam logic [3:0] P_GT = 4'd1;
  localparam logic [3:0] P_GT2 = 4'd2;
  localparam logic [3:0] P_LT = 4'd4;
  localparam logic [3:0] P_SHL = 4'd5;
  localparam logic [3:0] P_PLUS = 4'd7;
  localparam logic [3:0] P_MINUS = 4'd8;
  localparam logic [3:0] P_AMP = 4'd12;
  localparam logic [3:0] P_BAR = 4'd14;
  localparam logic [3:0] P_DOT = 4'd15;

  // number flag codes
  localparam logic [2:0] NF_INT = 3'd0;
  localparam logic [2:0] NF_DOT = 3'd1;
  localparam logic [2:0] NF_EXP = 3'd2;
  localparam logic [2:0] NF_EXP_D = 3'd3;
  localparam logic [2:0] NF_DEXP = 3'd4;
  localparam logic [2:0] NF_DEXP_D = 3'd5;
  localparam logic [2:0] NF_DOT_AFT = 3'd6;

  typedef enum logic [3:0] {
    M_IDLE, M_WS, M_LT, M_ID, M_NUM, M_PUNCT, M_STR, M_ESC, M_HALT
  } scan_mode_t;

  typedef logic [WORD_BUFFER_CHARS-1:0][6:0] wbuf_t;

  typedef struct packed {
    logic [6:0] kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [2:0] err;
  } tok_t;

  localparam logic [71:0] WORD_TXT [20] = '{
    "undefined", "null", "false", "true", "break", "continue", "delete", "else",
    "for", "function", "if", "in", "new", "return", "this", "typeof", "var",
    "void", "while", "with"};
  localparam int WORD_LEN [20] = '{9, 4, 5, 4, 5, 8, 6, 4, 3, 8, 2, 2, 3, 6, 4, 6, 3,
                                   4, 5, 4};

  function automatic logic is_ws(input logic [15:0] c);
    return c == 16'h09 || c == 16'h0B || c == 16'h0C || c == 16'h20;
  endfunction

  function automatic logic is_lt(input logic [15:0] c);
    return c == 16'h0A || c == 16'h0D;
  endfunction

  function automatic logic is_dig(input logic [15:0] c);
    return c >= 16'h30 && c <= 16'h39;
  endfunction

  function automatic logic is_letter(input logic [15:0] c);
    return c == 16'h5F || c == 16'h24 || (c >= 16'h61 && c <= 16'h7A) ||
           (c >= 16'h41 && c <= 16'h5A);
  endfunction

  // bit 4 flags a prefix character
  function automatic logic [4:0] prefix_of(input logic [15:0] c);
    logic [4:0] r;
    case (c)
      16'h3D: r = 5'h10;
      16'h3E: r = 5'h11;
      16'h3C: r = 5'h14;
      16'h21: r = 5'h16;
      16'h2B: r = 5'h17;
      16'h2D: r = 5'h18;
      16'h2A: r = 5'h19;
      16'h2F: r = 5'h1A;
      16'h25: r = 5'h1B;
      16'h26: r = 5'h1C;
      16'h5E: r = 5'h1D;
      16'h7C: r = 5'h1E;
      16'h2E: r = 5'h1F;
      default: r = 5'h00;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] single_kind(input logic [15:0] c);
    logic [6:0] r;
    case (c)
      16'h2C: r = 7'd12;
      16'h7E: r = 7'd14;
      16'h3F: r = 7'd15;
      16'h3A: r = 7'd16;
      16'h28: r = 7'd44;
      16'h29: r = 7'd45;
      16'h7B: r = 7'd46;
      16'h7D: r = 7'd47;
      16'h5B: r = 7'd48;
      16'h5D: r = 7'd49;
      16'h3B: r = 7'd50;
      default: r = K_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] lone_kind(input logic [3:0] pf);
    logic [6:0] r;
    case (pf)
      4'd0: r = 7'd5;   4'd1: r = 7'd6;   4'd2: r = 7'd31;  4'd3: r = 7'd32;
      4'd4: r = 7'd7;   4'd5: r = 7'd30;  4'd6: r = 7'd13;  4'd7: r = 7'd22;
      4'd8: r = 7'd23;  4'd9: r = 7'd24;  4'd10: r = 7'd25; 4'd11: r = 7'd29;
      4'd12: r = 7'd26; 4'd13: r = 7'd28; 4'd14: r = 7'd27; default: r = 7'd17;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] eq_kind(input logic [3:0] pf);
    logic [6:0] r;
    case (pf)
      4'd0: r = 7'd8;   4'd1: r = 7'd10;  4'd2: r = 7'd42;  4'd3: r = 7'd43;
      4'd4: r = 7'd9;   4'd5: r = 7'd41;  4'd6: r = 7'd11;  4'd7: r = 7'd33;
      4'd8: r = 7'd34;  4'd9: r = 7'd35;  4'd10: r = 7'd36; 4'd11: r = 7'd40;
      4'd12: r = 7'd37; 4'd13: r = 7'd39; 4'd14: r = 7'd38; default: r = K_NONE;
    endcase
    return r;
  endfunction

  // parallel reserved-word compare against the buffered identifier
  function automatic logic [6:0] word_kind(input wbuf_t wb, input logic wl,
                                           input logic [LEN_W-1:0] len);
    logic [6:0] r;
    logic same;
    r = K_ID;
    if (!wl && len <= LEN_W'(WORD_BUFFER_CHARS)) begin
      for (int w = 0; w < 20; w++) begin
        same = (len == LEN_W'(WORD_LEN[w]));
        for (int k = 0; k < WORD_BUFFER_CHARS; k++) begin
          if (k < WORD_LEN[w] && wb[k] != WORD_TXT[w][8*(WORD_LEN[w]-1-k) +: 7]) begin
            same = 1'b0;
          end
        end
        if (same) r = K_WORD0 + 7'(w);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/script_source_tokenizer.sv
`default_nettype none
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall  | char_code, last_char
// out_     | output    | out_valid/out_stall| token_kind, token_start, token_length,
//          |           |                    | error_code, last_of_run
// one character is scanned per cycle while in_stall is low, in a single combinational pass, and its
// 0 to 3 tokens land in a result queue; the queue drains one token per cycle while out_stall is low,
// so a character is taken every cycle while each gives at most one token.
// reset is synchronous; no clearing pass is needed.
// out_stall holds the queue; the next character waits until the queue's
// final token transfers.
module script_source_tokenizer import sst_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        in_char_code,
  input  wire logic               in_last_char,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [6:0]              out_token_kind,
  output logic [START_W-1:0]      out_token_start,
  output logic [LEN_W-1:0]        out_token_length,
  output logic [2:0]              out_error_code,
  output logic                    out_last_of_run
);

  // scanner state
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [START_W-1:0] ps_r, ps_nxt;
  scan_mode_t         mode_r, mode_nxt;
  logic               qd_r, qd_nxt;
  logic [2:0]         nf_r, nf_nxt;
  logic [3:0]         pp_r, pp_nxt;
  wbuf_t              wb_r, wb_nxt;
  logic               wl_r, wl_nxt;

  // result queue
  tok_t       q_r [3];
  tok_t       res [3];
  logic [1:0] cnt_r, idx_r, n;

  logic in_xfer, out_xfer, q_last;

  assign out_valid = (cnt_r != 2'd0);
  assign q_last = (idx_r == cnt_r - 2'd1);
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = out_valid && !(out_xfer && q_last);
  assign in_xfer = in_valid && !in_stall;

  assign out_token_kind = q_r[idx_r].kind;
  assign out_token_start = q_r[idx_r].start;
  assign out_token_length = q_r[idx_r].len;
  assign out_error_code = q_r[idx_r].err;
  assign out_last_of_run = q_last;

  // single-pass scan of one character
  always_comb begin
    logic [15:0]        c;
    logic [START_W-1:0] p;
    logic [LEN_W-1:0]   len, clen;
    logic               used, stp, clr, cerr, last;
    logic [6:0]         k, sk;
    logic [4:0]         pfx;
    tok_t               t;

    c = in_char_code;
    last = in_last_char;
    pos_nxt = pos_r;
    ps_nxt = ps_r;
    mode_nxt = mode_r;
    qd_nxt = qd_r;
    nf_nxt = nf_r;
    pp_nxt = pp_r;
    wb_nxt = wb_r;
    wl_nxt = wl_r;
    for (int i = 0; i < 3; i++) res[i] = '0;
    n = 2'd0;
    used = 1'b0;
    stp = 1'b0;
    clr = 1'b0;
    cerr = 1'b0;
    k = K_NONE;
    sk = K_NONE;
    pfx = '0;
    t = '0;
    clen = '0;
    p = pos_r[START_W-1:0];
    len = {1'b0, p} - {1'b0, ps_r};

    if (mode_r == M_HALT) begin
      used = 1'b1;
      clr = last;
    end else if (pos_r >= POS_W'(MAX_TEXT_LEN)) begin
      res[n] = '{K_WS, '0, '0, E_TOO_LONG};
      n = n + 2'd1;
      stp = 1'b1;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (mode_r)
        M_WS: used = is_ws(c);
        M_LT: used = is_lt(c);
        M_ID: begin
          if (is_letter(c) || is_dig(c)) begin
            used = 1'b1;
            if (len < LEN_W'(WORD_BUFFER_CHARS)) wb_nxt[len[WIDX_W-1:0]] = c[6:0];
            else wl_nxt = 1'b1;
          end
        end
        M_NUM: begin
          if (is_dig(c)) begin
            used = 1'b1;
            if (nf_r == NF_EXP) nf_nxt = NF_EXP_D;
            else if (nf_r == NF_DEXP) nf_nxt = NF_DEXP_D;
          end else if (c == 16'h2E) begin
            if (nf_r == NF_INT) begin
              used = 1'b1; nf_nxt = NF_DOT;
            end else if (nf_r == NF_EXP || nf_r == NF_EXP_D) begin
              used = 1'b1; nf_nxt = NF_DOT_AFT;
            end
          end else if (c == 16'h65 || c == 16'h45) begin
            if (nf_r == NF_INT) begin
              used = 1'b1; nf_nxt = NF_EXP;
            end else if (nf_r == NF_DOT) begin
              used = 1'b1; nf_nxt = NF_DEXP;
            end
          end
        end
        M_PUNCT: begin
          if (pp_r == P_DOT && is_dig(c)) begin
            mode_nxt = M_NUM; nf_nxt = NF_DOT; used = 1'b1;
          end else if (c == 16'h3D && eq_kind(pp_r) != K_NONE) begin
            k = eq_kind(pp_r);
          end else if (c == 16'h3E && (pp_r == P_GT || pp_r == P_GT2)) begin
            pp_nxt = pp_r + 4'd1; used = 1'b1;
          end else if (c == 16'h3C && pp_r == P_LT) begin
            pp_nxt = P_SHL; used = 1'b1;
          end else if (c == 16'h2B && pp_r == P_PLUS) k = K_INC;
          else if (c == 16'h2D && pp_r == P_MINUS) k = K_DEC;
          else if (c == 16'h26 && pp_r == P_AMP) k = K_AND;
          else if (c == 16'h7C && pp_r == P_BAR) k = K_OR;
          if (k != K_NONE) begin
            res[n] = '{k, ps_r, len + LEN_W'(1), E_OK};
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            used = 1'b1;
          end
        end
        M_STR: begin
          used = 1'b1;
          if (is_lt(c)) begin
            res[n] = '{K_STR, ps_r, len + LEN_W'(1), E_NL_STR};
            n = n + 2'd1;
            stp = 1'b1;
          end else if (c == 16'h5C) begin
            mode_nxt = M_ESC;
          end else if (c == (qd_r ? 16'h22 : 16'h27)) begin
            res[n] = '{K_STR, ps_r, len + LEN_W'(1), E_OK};
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_ESC: begin
          used = 1'b1;
          res[n] = '{K_STR, ps_r, len + LEN_W'(1), is_lt(c) ? E_NL_STR : E_ESCAPE};
          n = n + 2'd1;
          stp = 1'b1;
        end
        default: ;
      endcase

      // close the pending token before this character, then start a new one unless the close found an error
      if (!stp && !used) begin
        cerr = 1'b0;
        t = '{K_WS, ps_nxt, len, E_OK};
        unique case (mode_nxt)
          M_WS: t.kind = K_WS;
          M_LT: t.kind = K_LT;
          M_ID: t.kind = word_kind(wb_nxt, wl_nxt, len);
          M_NUM: begin
            t.kind = K_NUM;
            if (nf_nxt == NF_EXP || nf_nxt == NF_DEXP || nf_nxt == NF_DOT_AFT) begin
              t.err = E_BAD_NUM; cerr = 1'b1;
            end
          end
          M_PUNCT: t.kind = lone_kind(pp_nxt);
          M_STR, M_ESC: begin
            t.kind = K_STR; t.err = E_UNTERM; cerr = 1'b1;
          end
          default: ;
        endcase
        if (mode_nxt != M_IDLE && mode_nxt != M_HALT) begin
          res[n] = t;
          n = n + 2'd1;
        end
        mode_nxt = M_IDLE;
        if (cerr) begin
          stp = 1'b1;
        end else begin
          pfx = prefix_of(c);
          sk = single_kind(c);
          ps_nxt = p;
          if (c == 16'h22 || c == 16'h27) begin
            mode_nxt = M_STR; qd_nxt = (c == 16'h22);
          end else if (is_ws(c)) mode_nxt = M_WS;
          else if (is_lt(c)) mode_nxt = M_LT;
          else if (is_letter(c)) begin
            mode_nxt = M_ID; wb_nxt[0] = c[6:0]; wl_nxt = 1'b0;
          end else if (is_dig(c)) begin
            mode_nxt = M_NUM; nf_nxt = NF_INT;
          end else if (pfx[4]) begin
            mode_nxt = M_PUNCT; pp_nxt = pfx[3:0];
          end else if (sk != K_NONE) begin
            res[n] = '{sk, p, LEN_W'(1), E_OK};
            n = n + 2'd1;
          end else begin
            res[n] = '{K_WS, p, LEN_W'(1), E_BAD_CHAR};
            n = n + 2'd1;
            stp = 1'b1;
          end
        end
      end

      // last character: flush and add the end token unless the flush found an error
      if (!stp && last) begin
        cerr = 1'b0;
        clen = POS_W'(pos_nxt) - {1'b0, ps_nxt};
        t = '{K_WS, ps_nxt, clen, E_OK};
        unique case (mode_nxt)
          M_WS: t.kind = K_WS;
          M_LT: t.kind = K_LT;
          M_ID: t.kind = word_kind(wb_nxt, wl_nxt, clen);
          M_NUM: begin
            t.kind = K_NUM;
            if (nf_nxt == NF_EXP || nf_nxt == NF_DEXP || nf_nxt == NF_DOT_AFT) begin
              t.err = E_BAD_NUM; cerr = 1'b1;
            end
          end
          M_PUNCT: t.kind = lone_kind(pp_nxt);
          M_STR, M_ESC: begin
            t.kind = K_STR; t.err = E_UNTERM; cerr = 1'b1;
          end
          default: ;
        endcase
        if (mode_nxt != M_IDLE && mode_nxt != M_HALT) begin
          res[n] = t;
          n = n + 2'd1;
        end
        if (cerr) begin
          stp = 1'b1;
        end else begin
          res[n] = '{K_END, pos_nxt[START_W-1:0], '0, E_OK};
          n = n + 2'd1;
          clr = 1'b1;
        end
      end
    end

    if (stp) begin
      if (last) clr = 1'b1;
      else mode_nxt = M_HALT;
    end
    if (clr) begin
      pos_nxt = '0;
      ps_nxt = '0;
      mode_nxt = M_IDLE;
      qd_nxt = 1'b0;
      nf_nxt = '0;
      pp_nxt = '0;
      wb_nxt = '0;
      wl_nxt = 1'b0;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ps_r <= '0;
      mode_r <= M_IDLE;
      qd_r <= 1'b0;
      nf_r <= '0;
      pp_r <= '0;
      wl_r <= 1'b0;
    end else if (in_xfer) begin
      pos_r <= pos_nxt;
      ps_r <= ps_nxt;
      mode_r <= mode_nxt;
      qd_r <= qd_nxt;
      nf_r <= nf_nxt;
      pp_r <= pp_nxt;
      wl_r <= wl_nxt;
    end
  end

  // word buffer, undefined until written
  always_ff @(posedge clk) begin
    if (in_xfer) wb_r <= wb_nxt;
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (in_xfer) begin
      cnt_r <= n;
      idx_r <= '0;
    end else if (out_xfer) begin
      if (q_last) cnt_r <= '0;
      else idx_r <= idx_r + 2'd1;
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < 3; i++) q_r[i] <= res[i];
    end
  end

  // checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r < cnt_r))
    else $error("queue index beyond count");

  a_accept_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && out_valid) |-> (out_xfer && q_last))
    else $error("character taken while queue still holds tokens");

  a_results_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && n != 2'd0) |=> (out_valid && idx_r == 2'd0))
    else $error("tokens of a character not presented");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
  import sst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_char_code = '0;
  logic in_last_char = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] out_token_kind;
  logic [START_W-1:0] out_token_start;
  logic [LEN_W-1:0] out_token_length;
  logic [2:0] out_error_code;
  logic out_last_of_run;

  script_source_tokenizer i_dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [6:0] kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [2:0] err;
    logic last_run;
  } token_t;

  token_t expected_tokens[$];
  token_t step_tokens[$];
  int failures = 0;
  int burst_left = 0;

  // lexer state of the scoreboard
  logic [20:0] char_pos;
  logic [19:0] tok_start;
  scan_mode_t mode;
  bit quote_dq;
  logic [2:0] num_state;
  logic [3:0] punct_pf;
  logic [6:0] word_chars[WORD_BUFFER_CHARS];
  bit word_long;

  // prefix codes: = > >> >>> < << ! + - * / % & ^ | .
  const logic [6:0] lone_tab[16] = '{5, 6, 31, 32, 7, 30, 13, 22, 23, 24, 25, 29, 26, 28,
                                     27, 17};
  const logic [6:0] eq_tab[16] = '{8, 10, 42, 43, 9, 41, 11, 33, 34, 35, 36, 40, 37, 39,
                                   38, K_NONE};
  const string reserved[20] = '{"undefined", "null", "false", "true", "break", "continue",
    "delete", "else", "for", "function", "if", "in", "new", "return", "this", "typeof",
    "var", "void", "while", "with"};
  const string punct_txt[46] = '{"=", ">", "<", "==", "<=", ">=", "!=", ",", "!", "~", "?",
    ":", ".", "&&", "||", "++", "--", "+", "-", "*", "/", "&", "|", "^", "%", "<<", ">>",
    ">>>", "+=", "-=", "*=", "/=", "&=", "|=", "^=", "%=", "<<=", ">>=", ">>>=", "(", ")",
    "{", "}", "[", "]", ";"};

  function automatic bit c_ws(logic [15:0] c);
    return c == 16'h09 || c == 16'h0B || c == 16'h0C || c == 16'h20;
  endfunction
  function automatic bit c_lt(logic [15:0] c);
    return c == 16'h0A || c == 16'h0D;
  endfunction
  function automatic bit c_dig(logic [15:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit c_letter(logic [15:0] c);
    return c == "_" || c == "$" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic int pf_code(logic [15:0] c);
    case (c)
      "=": return 0;  ">": return 1;  "<": return 4;  "!": return 6;
      "+": return 7;  "-": return 8;  "*": return 9;  "/": return 10;
      "%": return 11; "&": return 12; "^": return 13; "|": return 14;
      ".": return 15;
      default: return -1;
    endcase
  endfunction

  function automatic logic [6:0] one_char_kind(logic [15:0] c);
    case (c)
      ",": return 12; "~": return 14; "?": return 15; ":": return 16;
      "(": return 44; ")": return 45; "{": return 46; "}": return 47;
      "[": return 48; "]": return 49; ";": return 50;
      default: return K_NONE;
    endcase
  endfunction

  function automatic void add_tok(logic [6:0] k, logic [20:0] s, logic [20:0] l,
                                  logic [2:0] e);
    token_t t;
    t.kind = k;
    t.start = s[19:0];
    t.len = l;
    t.err = e;
    t.last_run = 1'b0;
    step_tokens = {step_tokens, t};
  endfunction

  function automatic void lexer_clear();
    char_pos = '0;
    tok_start = '0;
    mode = M_IDLE;
    quote_dq = 0;
    num_state = NF_INT;
    punct_pf = '0;
    foreach (word_chars[i]) word_chars[i] = '0;
    word_long = 0;
  endfunction

  function automatic logic [6:0] ident_kind(logic [20:0] len);
    bit same;
    if (word_long || len > WORD_BUFFER_CHARS) return K_ID;
    for (int w = 0; w < 20; w++) begin
      if (reserved[w].len() != len) continue;
      same = 1;
      for (int k = 0; k < len; k++)
        if (word_chars[k] != 7'(reserved[w][k])) same = 0;
      if (same) return K_WORD0 + 7'(w);
    end
    return K_ID;
  endfunction

  // emit the pending token ending before offset stop_at; returns 1 on error
  function automatic bit close_pending(logic [20:0] stop_at);
    logic [20:0] len;
    bit bad;
    len = stop_at - {1'b0, tok_start};
    bad = 0;
    case (mode)
      M_WS: add_tok(K_WS, tok_start, len, E_OK);
      M_LT: add_tok(K_LT, tok_start, len, E_OK);
      M_ID: add_tok(ident_kind(len), tok_start, len, E_OK);
      M_NUM: begin
        if (num_state == NF_EXP || num_state == NF_DEXP || num_state == NF_DOT_AFT) begin
          add_tok(K_NUM, tok_start, len, E_BAD_NUM);
          bad = 1;
        end else begin
          add_tok(K_NUM, tok_start, len, E_OK);
        end
      end
      M_PUNCT: add_tok(lone_tab[punct_pf], tok_start, len, E_OK);
      M_STR, M_ESC: begin
        add_tok(K_STR, tok_start, len, E_UNTERM);
        bad = 1;
      end
      default: ;
    endcase
    mode = M_IDLE;
    return bad;
  endfunction

  // open a new token with character c at offset p; returns 1 on error
  function automatic bit open_token(logic [15:0] c, logic [20:0] p);
    int pf;
    logic [6:0] sk;
    pf = pf_code(c);
    sk = one_char_kind(c);
    tok_start = p[19:0];
    if (c == "\"" || c == "'") begin
      mode = M_STR;
      quote_dq = (c == "\"");
    end else if (c_ws(c)) mode = M_WS;
    else if (c_lt(c)) mode = M_LT;
    else if (c_letter(c)) begin
      mode = M_ID;
      word_chars[0] = c[6:0];
      word_long = 0;
    end else if (c_dig(c)) begin
      mode = M_NUM;
      num_state = NF_INT;
    end else if (pf >= 0) begin
      mode = M_PUNCT;
      punct_pf = 4'(pf);
    end else if (sk != K_NONE) add_tok(sk, p, 1, E_OK);
    else begin
      add_tok(K_WS, p, 1, E_BAD_CHAR);
      return 1;
    end
    return 0;
  endfunction

  function automatic int num_advance(logic [2:0] f, logic [15:0] c);
    if (c_dig(c)) return f == NF_EXP ? NF_EXP_D : (f == NF_DEXP ? NF_DEXP_D : f);
    if (c == ".") return f == NF_INT ? NF_DOT : ((f == NF_EXP || f == NF_EXP_D) ? NF_DOT_AFT : -1);
    if (c == "e" || c == "E") return f == NF_INT ? NF_EXP : (f == NF_DOT ? NF_DEXP : -1);
    return -1;
  endfunction

  // tokens caused by one character, before marking the final one
  function automatic bit scan_char(logic [15:0] c, bit last);
    logic [20:0] p, len;
    bit used;
    int r;
    logic [6:0] k;
    used = 0;
    if (char_pos >= MAX_TEXT_LEN) begin
      add_tok(K_WS, 0, 0, E_TOO_LONG);
      return 1;
    end
    p = char_pos;
    char_pos = p + 1;
    len = p - {1'b0, tok_start};
    case (mode)
      M_WS: used = c_ws(c);
      M_LT: used = c_lt(c);
      M_ID: begin
        if (c_letter(c) || c_dig(c)) begin
          used = 1;
          if (len < WORD_BUFFER_CHARS) word_chars[len] = c[6:0];
          else word_long = 1;
        end
      end
      M_NUM: begin
        r = num_advance(num_state, c);
        if (r >= 0) begin
          used = 1;
          num_state = 3'(r);
        end
      end
      M_PUNCT: begin
        k = K_NONE;
        if (punct_pf == P_DOT && c_dig(c)) begin
          mode = M_NUM;
          num_state = NF_DOT;
          used = 1;
        end else if (c == "=" && eq_tab[punct_pf] != K_NONE) k = eq_tab[punct_pf];
        else if (c == ">" && (punct_pf == P_GT || punct_pf == P_GT2)) begin
          punct_pf = punct_pf + 1;
          used = 1;
        end else if (c == "<" && punct_pf == P_LT) begin
          punct_pf = P_SHL;
          used = 1;
        end else if (c == "+" && punct_pf == P_PLUS) k = K_INC;
        else if (c == "-" && punct_pf == P_MINUS) k = K_DEC;
        else if (c == "&" && punct_pf == P_AMP) k = K_AND;
        else if (c == "|" && punct_pf == P_BAR) k = K_OR;
        if (k != K_NONE) begin
          add_tok(k, tok_start, len + 1, E_OK);
          mode = M_IDLE;
          used = 1;
        end
      end
      M_STR: begin
        used = 1;
        if (c_lt(c)) begin
          add_tok(K_STR, tok_start, len + 1, E_NL_STR);
          return 1;
        end
        if (c == "\\") mode = M_ESC;
        else if (c == (quote_dq ? 16'h22 : 16'h27)) begin
          add_tok(K_STR, tok_start, len + 1, E_OK);
          mode = M_IDLE;
        end
      end
      M_ESC: begin
        add_tok(K_STR, tok_start, len + 1, c_lt(c) ? E_NL_STR : E_ESCAPE);
        return 1;
      end
      default: ;
    endcase
    if (!used) begin
      if (close_pending(p)) return 1;
      if (open_token(c, p)) return 1;
    end
    if (last) begin
      if (close_pending(char_pos)) return 1;
      add_tok(K_END, char_pos, 0, E_OK);
      lexer_clear();
    end
    return 0;
  endfunction

  // predict the tokens of one accepted character
  function automatic void predict_tokens(logic [15:0] c, bit last);
    step_tokens.delete();
    if (mode == M_HALT) begin
      if (last) lexer_clear();
      return;
    end
    if (scan_char(c, last)) begin
      if (last) lexer_clear();
      else mode = M_HALT;
    end
    if (step_tokens.size() > 0) step_tokens[$].last_run = 1'b1;
    expected_tokens = {expected_tokens, step_tokens};
  endfunction

  // send one character, with bursts and gaps on the sender side
  task automatic send_char(logic [15:0] c, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid = 1'b1;
    in_char_code = c;
    in_last_char = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(c, last);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_text(string s, bit term);
    for (int i = 0; i < s.len(); i++) send_char(16'(s[i]), term && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    while (expected_tokens.size() != 0) @(negedge clk);
  endtask

  // receiver stall pattern: quiet stretches, random stalls and long holds
  int stall_cyc = 0;
  always @(negedge clk) begin
    stall_cyc <= stall_cyc + 1;
    case (stall_cyc[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 2) == 0);
      2'd2: out_stall <= (stall_cyc[3:0] < 4'd11);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // compare each result transfer with the oldest expected token
  always @(posedge clk) begin
    token_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token kind %0d start %0d", out_token_kind, out_token_start);
        failures++;
      end else begin
        t = expected_tokens.pop_front();
        if (out_token_kind !== t.kind) begin
          $error("token_kind expected %0d actual %0d", t.kind, out_token_kind);
          failures++;
        end
        if (out_token_start !== t.start) begin
          $error("token_start expected %0d actual %0d", t.start, out_token_start);
          failures++;
        end
        if (out_token_length !== t.len) begin
          $error("token_length expected %0d actual %0d", t.len, out_token_length);
          failures++;
        end
        if (out_error_code !== t.err) begin
          $error("error_code expected %0d actual %0d", t.err, out_error_code);
          failures++;
        end
        if (out_last_of_run !== t.last_run) begin
          $error("last_of_run expected %0d actual %0d", t.last_run, out_last_of_run);
          failures++;
        end
      end
    end
  end

  // corner cases: number forms, shifts, strings, errors, halt and extremes
  task automatic test_directed();
    send_text("if(a>>>=.5e3)", 1'b0);
    send_text("1e;", 1'b0);
    send_text("'x", 1'b1);
    send_text("\"a\\n", 1'b1);
    send_char(16'hFFFF, 1'b0);
    send_char(16'h0000, 1'b1);
    send_text("1.e", 1'b1);
    send_text("2e5.", 1'b1);
    send_text("'\n", 1'b1);
    send_text(".", 1'b1);
  endtask

  // well-formed token streams with random content, plus noise
  task automatic test_random(int n_chars);
    int sent;
    int sel;
    string s;
    sent = 0;
    while (sent < n_chars) begin
      sel = $urandom_range(0, 99);
      s = "";
      if (sel < 15) s = reserved[$urandom_range(0, 19)];
      else if (sel < 25) begin
        repeat ($urandom_range(1, 12)) s = {s, string'(8'($urandom_range(0, 1) ?
                                        $urandom_range("a", "z") : $urandom_range("A", "Z")))};
        if ($urandom_range(0, 2) == 0) s = {s, "_9$"};
      end else if (sel < 35) begin
        s = $sformatf("%0d", $urandom_range(0, 999));
        if ($urandom_range(0, 1)) s = {s, ".", $sformatf("%0d", $urandom_range(0, 99))};
        if ($urandom_range(0, 2) == 0) s = {s, "e", $sformatf("%0d", $urandom_range(0, 9))};
        if ($urandom_range(0, 9) == 0) s = {".", s};
      end else if (sel < 42) s = $urandom_range(0, 1) ? "\"ab c\"" : "'q+1'";
      else if (sel < 60) s = punct_txt[$urandom_range(0, 45)];
      else if (sel < 75) s = $urandom_range(0, 1) ? " \t" : "\x0b\x0c ";
      else if (sel < 82) s = $urandom_range(0, 1) ? "\n" : "\r\n";
      else if (sel < 85) s = $urandom_range(0, 1) ? "1e+" : "'bad\\";
      if (sel >= 85 && sel < 92) begin
        send_char(16'($urandom()), 1'b0);
        sent++;
      end else if (sel >= 92) begin
        send_char(16'($urandom_range(0, 127)), $urandom_range(0, 3) == 0);
        sent++;
      end else begin
        send_text(s, 1'b0);
        sent += s.len();
      end
      if ($urandom_range(0, 11) == 0) begin
        send_char(" ", 1'b1);
        sent++;
      end
      if (sent > n_chars / 2 && sent < n_chars / 2 + 4) wait_drained();
    end
    send_char(";", 1'b1);
  endtask

  initial begin
    lexer_clear();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    wait_drained();
    test_random(175);
    wait_drained();
    repeat (20) @(negedge clk);
    if (failures == 0 && expected_tokens.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // run limit
  initial begin
    #1ms;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
